### sv/ssqs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssqs_pkg;

  // Queue and service sizing.
  localparam int QUEUE_DEPTH = 64;
  localparam int MAX_SERVICE = 15;

  // Widths that follow from the sizing above.
  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int BUSY_W = $clog2(MAX_SERVICE + 1);

  // Fixed field widths of the channels.
  localparam int SVC_W   = 4;
  localparam int STAMP_W = 16;
  localparam int CNT_W   = 32;
  localparam int DROP_W  = 16;
  localparam int QLEN_W  = 7;
  localparam int LEFT_W  = 4;

  // One tick request as held in the input register.
  typedef struct packed {
    logic             arrives;
    logic [SVC_W-1:0] svc;
  } tick_req_t;

  // One waiting call as stored in the queue.
  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [BUSY_W-1:0]  svc;
  } call_t;

  // Queue control from the tick logic.
  typedef struct packed {
    logic  push;
    logic  pop;
    call_t wdata;
  } fifo_ctl_t;

  // Queue status toward the tick logic.
  typedef struct packed {
    logic [OCC_W-1:0] occ;
    call_t            head;
  } fifo_stat_t;

endpackage

`default_nettype wire

### sv/ssqs_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module ssqs_in_stage
  import ssqs_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             call_arrives_i,
  input  wire logic [SVC_W-1:0] service_time_i,
  input  wire logic             advance_i,
  output logic                  req_valid_o,
  output tick_req_t             req_o
);

  logic      vld_q, vld_d;
  logic      load;
  tick_req_t req_q;

  // The register frees up in the same cycle that its request moves on.
  assign in_stall_o = vld_q & ~advance_i;
  assign load       = in_valid_i & ~in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (advance_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload capture needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q.arrives <= call_arrives_i;
      req_q.svc     <= service_time_i;
    end
  end

  assign req_valid_o = vld_q;
  assign req_o       = req_q;

endmodule

`default_nettype wire

### sv/ssqs_call_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module ssqs_call_fifo
  import ssqs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire fifo_ctl_t ctl_i,
  output fifo_stat_t     stat_o
);

  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [OCC_W-1:0] occ_q, occ_d;
  call_t            mem [QUEUE_DEPTH];
  call_t            rd_q;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Pointer and fill level updates.
  always_comb begin
    head_d = ctl_i.pop  ? next_slot(head_q) : head_q;
    tail_d = ctl_i.push ? next_slot(tail_q) : tail_q;
    occ_d  = occ_q + OCC_W'(ctl_i.push) - OCC_W'(ctl_i.pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      occ_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      occ_q  <= occ_d;
    end
  end

  // Call store. The read port fetches the next head every cycle, so the
  // registered read data always holds the current head entry; a write to
  // that same slot is forwarded.
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem[tail_q] <= ctl_i.wdata;
    end
    if (ctl_i.push && (tail_q == head_d)) begin
      rd_q <= ctl_i.wdata;
    end else begin
      rd_q <= mem[head_d];
    end
  end

  assign stat_o.occ  = occ_q;
  assign stat_o.head = rd_q;

endmodule

`default_nettype wire

### sv/ssqs_tick_core.sv
`timescale 1ns / 1ps
`default_nettype none

module ssqs_tick_core
  import ssqs_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             advance_i,
  input  wire tick_req_t        req_i,
  input  wire fifo_stat_t       fifo_i,
  output fifo_ctl_t             fifo_o,
  input  wire logic             out_stall_i,
  output logic                  out_valid_o,
  output logic [CNT_W-1:0]      arrived_o,
  output logic [CNT_W-1:0]      served_o,
  output logic [CNT_W-1:0]      wait_o,
  output logic [OCC_W-1:0]      max_occ_o,
  output logic [BUSY_W-1:0]     busy_o,
  output logic [DROP_W-1:0]     drop_o
);

  logic                out_vld_q, out_vld_d;
  logic [STAMP_W-1:0]  tick_q, tick_d;
  logic [BUSY_W-1:0]   busy_q, busy_d;
  logic [CNT_W-1:0]    arrived_q, arrived_d;
  logic [CNT_W-1:0]    served_q, served_d;
  logic [CNT_W-1:0]    wait_q, wait_d;
  logic [OCC_W-1:0]    max_occ_q, max_occ_d;
  logic [DROP_W-1:0]   drop_q, drop_d;

  logic [BUSY_W-1:0]   svc_c;
  logic                full;
  logic                push, pop;
  logic [OCC_W-1:0]    occ_pushed, occ_end;
  logic [BUSY_W-1:0]   busy_dec;
  call_t               head_call;
  logic [STAMP_W-1:0]  wait_ticks;
  logic [CNT_W:0]      wait_sum_c;

  // Arrival: clamp the service time and enqueue unless the queue is full.
  always_comb begin
    svc_c      = (32'(req_i.svc) > MAX_SERVICE) ? BUSY_W'(MAX_SERVICE) : BUSY_W'(req_i.svc);
    full       = (32'(fifo_i.occ) >= QUEUE_DEPTH);
    push       = advance_i & req_i.arrives & ~full;
    occ_pushed = fifo_i.occ + OCC_W'(push);
  end

  // Service: count down, then start the head call once the server is idle.
  always_comb begin
    busy_dec   = (busy_q != '0) ? busy_q - 1'b1 : busy_q;
    pop        = advance_i & (busy_dec == '0) & (occ_pushed != '0);
    // An empty queue can only start the call that arrived in this tick.
    if (fifo_i.occ == '0) begin
      head_call.stamp = tick_q;
      head_call.svc   = svc_c;
    end else begin
      head_call = fifo_i.head;
    end
    wait_ticks = tick_q - head_call.stamp;
    wait_sum_c = {1'b0, wait_q} + (CNT_W + 1)'(wait_ticks);
    occ_end    = occ_pushed - OCC_W'(pop);
  end

  assign fifo_o.push        = push;
  assign fifo_o.pop         = pop;
  assign fifo_o.wdata.stamp = tick_q;
  assign fifo_o.wdata.svc   = svc_c;

  // Statistics update; the event and wait counters saturate, the tick number wraps.
  always_comb begin
    tick_d    = tick_q;
    busy_d    = busy_q;
    arrived_d = arrived_q;
    served_d  = served_q;
    wait_d    = wait_q;
    max_occ_d = max_occ_q;
    drop_d    = drop_q;
    if (advance_i) begin
      tick_d = tick_q + 1'b1;
      busy_d = pop ? head_call.svc : busy_dec;
      if (req_i.arrives && (arrived_q != '1)) begin
        arrived_d = arrived_q + 1'b1;
      end
      if (req_i.arrives && full && (drop_q != '1)) begin
        drop_d = drop_q + 1'b1;
      end
      if (pop) begin
        if (served_q != '1) begin
          served_d = served_q + 1'b1;
        end
        wait_d = wait_sum_c[CNT_W] ? '1 : wait_sum_c[CNT_W-1:0];
      end
      if (occ_end > max_occ_q) begin
        max_occ_d = occ_end;
      end
    end
  end

  // Result handshake: a new result replaces a taken or empty one.
  always_comb begin
    out_vld_d = out_vld_q;
    if (advance_i) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      tick_q    <= '0;
      busy_q    <= '0;
      arrived_q <= '0;
      served_q  <= '0;
      wait_q    <= '0;
      max_occ_q <= '0;
      drop_q    <= '0;
    end else begin
      out_vld_q <= out_vld_d;
      tick_q    <= tick_d;
      busy_q    <= busy_d;
      arrived_q <= arrived_d;
      served_q  <= served_d;
      wait_q    <= wait_d;
      max_occ_q <= max_occ_d;
      drop_q    <= drop_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign arrived_o   = arrived_q;
  assign served_o    = served_q;
  assign wait_o      = wait_q;
  assign max_occ_o   = max_occ_q;
  assign busy_o      = busy_q;
  assign drop_o      = drop_q;

endmodule

`default_nettype wire

### sv/single_server_queue_stats.sv
`timescale 1ns / 1ps
`default_nettype none

// Discrete-time single-server queue with running statistics.
// Each input request is one tick: call_arrives_i says whether a call arrives,
// service_time_i gives its service ticks. Each tick yields one result with
// the counters, the longest and current queue length and the server's
// remaining time, all as they stand at the end of that tick.
// Both channels use valid/stall; a request moves at a clock edge with valid
// high and stall low.
// A request accepted into the input register is applied as a tick once the
// result register is empty or being taken; the result then shows on the output.
// Throughput: one tick per clock while the receiver does not stall. The queue
// store's read port prefetches the next head entry each cycle, so back-to-back
// starts need no wait. When the receiver stalls, the result register holds;
// the input register still takes one more request and then stalls the sender.
// Reset clears the pointers, counters, tick number and both valid flags;
// the queue store holds nothing meaningful until calls are written.
module single_server_queue_stats
  import ssqs_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              call_arrives_i,
  input  wire logic [SVC_W-1:0]  service_time_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [CNT_W-1:0]       arrived_total_o,
  output logic [CNT_W-1:0]       served_total_o,
  output logic [CNT_W-1:0]       wait_total_o,
  output logic [QLEN_W-1:0]      longest_queue_o,
  output logic [QLEN_W-1:0]      queue_now_o,
  output logic [LEFT_W-1:0]      server_left_o,
  output logic [DROP_W-1:0]      dropped_total_o
);

  logic              req_valid;
  tick_req_t         req;
  logic              advance;
  fifo_ctl_t         fifo_ctl;
  fifo_stat_t        fifo_stat;
  logic [OCC_W-1:0]  max_occ;
  logic [BUSY_W-1:0] busy;

  // A held tick is applied when the result register is empty or being taken.
  assign advance = req_valid & (~out_valid_o | ~out_stall_i);

  ssqs_in_stage u_in_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .call_arrives_i (call_arrives_i),
    .service_time_i (service_time_i),
    .advance_i      (advance),
    .req_valid_o    (req_valid),
    .req_o          (req)
  );

  ssqs_call_fifo u_call_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (fifo_ctl),
    .stat_o (fifo_stat)
  );

  ssqs_tick_core u_tick_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .req_i       (req),
    .fifo_i      (fifo_stat),
    .fifo_o      (fifo_ctl),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .arrived_o   (arrived_total_o),
    .served_o    (served_total_o),
    .wait_o      (wait_total_o),
    .max_occ_o   (max_occ),
    .busy_o      (busy),
    .drop_o      (dropped_total_o)
  );

  assign longest_queue_o = QLEN_W'(max_occ);
  assign queue_now_o     = QLEN_W'(fifo_stat.occ);
  assign server_left_o   = LEFT_W'(busy);

endmodule

`default_nettype wire

### sv/ssqs_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ssqs_checker
  import ssqs_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              call_arrives_i,
  input wire logic [SVC_W-1:0]  service_time_i,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [CNT_W-1:0]  arrived_total_o,
  input wire logic [CNT_W-1:0]  served_total_o,
  input wire logic [CNT_W-1:0]  wait_total_o,
  input wire logic [QLEN_W-1:0] longest_queue_o,
  input wire logic [QLEN_W-1:0] queue_now_o,
  input wire logic [LEFT_W-1:0] server_left_o,
  input wire logic [DROP_W-1:0] dropped_total_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its arrival and wait counters.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(arrived_total_o) && $stable(wait_total_o))
    else $error("result changed while stalled");

  // The current queue length never exceeds the recorded maximum.
  a_max_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> queue_now_o <= longest_queue_o)
    else $error("queue length above recorded maximum");

  // No call is started that never arrived.
  a_served_le_arrived: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> served_total_o <= arrived_total_o)
    else $error("more calls served than arrived");

  // Consecutive results differ by at most one arrival.
  a_arrival_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=>
      !out_valid_o || ((arrived_total_o - $past(arrived_total_o)) <= 32'd1))
    else $error("arrival count jumped between results");

endmodule

bind single_server_queue_stats ssqs_checker u_ssqs_checker (.*);

`default_nettype wire
